// ----- rtl/wec_pkg.sv -----
// Shared types, codes and float helpers for the weighted element-wise combiner.
// No dependencies; used by wec_fmul, wec_fadd and weighted_elementwise_combine.
package wec_pkg;

    localparam int unsigned LATENCY = 8;
    localparam int unsigned TAG_DEPTH = 7;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    typedef enum logic [1:0] {
        MODE_PROD = 2'd0,
        MODE_SUM  = 2'd1,
        MODE_MAX  = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    localparam logic CFG_OP_MODE      = 1'b0;
    localparam logic CFG_VALUE_FORMAT = 1'b1;

    typedef struct packed {
        logic nan;
        logic inf;
        logic zero;
        logic sign;
    } spec_t;

    typedef struct packed {
        mode_t       mode;
        logic        bf;
        logic [31:0] alt;
    } tag_t;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd48;
        found = 1'b0;
        for (int i = 47; i >= 0; i--)
        begin
            if (!found && v[i])
            begin
                n     = 6'(47 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // round to nearest even; carry out of the mantissa moves into the exponent
    function automatic logic [30:0] round_rne(input logic [7:0] ef, input logic [23:0] m,
                                              input logic g, input logic s);
        logic inc;
        inc = g & (s | m[0]);
        return {ef, m[22:0]} + 31'(inc);
    endfunction

endpackage

// ----- rtl/wec_fmul.sv -----
// Three-stage IEEE single precision multiplier, round to nearest even.
// Depends on wec_pkg.
module wec_fmul
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] p
);

    logic [7:0]  ea, eb, eae, ebe;
    logic [23:0] ma, mb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

    wec_pkg::spec_t s1_spec_reg, s1_spec_next, s2_spec_reg;
    logic [47:0] s1_prod_reg, s1_prod_next;
    logic [8:0]  s1_esum_reg, s1_esum_next;

    logic [5:0]  lz;
    logic [47:0] s2_pn_reg, s2_pn_next;
    logic signed [9:0] s2_e_reg, s2_e_next;

    logic signed [9:0] t;
    logic [5:0]  sh;
    logic [7:0]  ef;
    logic        ovf, lost;
    logic [47:0] ps;
    logic [30:0] r;
    logic [31:0] p_reg, p_next;

    always_comb
    begin
        ea     = a[30:23];
        eb     = b[30:23];
        eae    = (ea == 8'd0) ? 8'd1 : ea;
        ebe    = (eb == 8'd0) ? 8'd1 : eb;
        ma     = {|ea, a[22:0]};
        mb     = {|eb, b[22:0]};
        a_nan  = (&ea) & (|a[22:0]);
        b_nan  = (&eb) & (|b[22:0]);
        a_inf  = (&ea) & ~(|a[22:0]);
        b_inf  = (&eb) & ~(|b[22:0]);
        a_zero = ~(|a[30:0]);
        b_zero = ~(|b[30:0]);
        s1_spec_next.nan  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
        s1_spec_next.inf  = a_inf | b_inf;
        s1_spec_next.zero = a_zero | b_zero;
        s1_spec_next.sign = a[31] ^ b[31];
        s1_esum_next = {1'b0, eae} + {1'b0, ebe};
        s1_prod_next = ma * mb;
    end

    always_comb
    begin
        lz         = wec_pkg::lzc48(s1_prod_reg);
        s2_pn_next = s1_prod_reg << lz;
        s2_e_next  = $signed({1'b0, s1_esum_reg}) - 10'sd126 - $signed({4'b0, lz});
    end

    always_comb
    begin
        t   = 10'sd1 - s2_e_reg;
        ovf = 1'b0;
        if (s2_e_reg > 10'sd0)
        begin
            sh  = 6'd0;
            ef  = s2_e_reg[7:0];
            ovf = (s2_e_reg >= 10'sd255);
        end
        else
        begin
            sh = (t > 10'sd48) ? 6'd48 : t[5:0];
            ef = 8'd0;
        end
        ps   = s2_pn_reg >> sh;
        lost = |(s2_pn_reg & ((48'h1 << sh) - 48'h1));
        r    = wec_pkg::round_rne(ef, ps[47:24], ps[23], (|ps[22:0]) | lost);
        if (s2_spec_reg.nan)
            p_next = wec_pkg::CANON_NAN;
        else if (s2_spec_reg.inf || ovf)
            p_next = {s2_spec_reg.sign, 8'hFF, 23'd0};
        else if (s2_spec_reg.zero)
            p_next = {s2_spec_reg.sign, 31'd0};
        else
            p_next = {s2_spec_reg.sign, r};
    end

    always_ff @(posedge clk)
    begin
        s1_spec_reg <= s1_spec_next;
        s1_prod_reg <= s1_prod_next;
        s1_esum_reg <= s1_esum_next;
        s2_spec_reg <= s1_spec_reg;
        s2_pn_reg   <= s2_pn_next;
        s2_e_reg    <= s2_e_next;
        p_reg       <= p_next;
    end

    assign p = p_reg;

endmodule

// ----- rtl/wec_fadd.sv -----
// Four-stage IEEE single precision adder: align, add, normalize, round.
// Depends on wec_pkg.
module wec_fadd
(
    input  logic        clk,
    input  logic [31:0] x,
    input  logic [31:0] y,
    output logic [31:0] s
);

    logic [31:0] big, sml;
    logic [7:0]  exb, exs, d;
    logic [26:0] smf, sm_sh;
    logic        x_nan, y_nan, x_inf, y_inf, lost;

    wec_pkg::spec_t a1_spec_reg, a1_spec_next, a2_spec_reg, a3_spec_reg;
    logic        a1_sub_reg, a1_sub_next, a1_zs_reg, a1_zs_next;
    logic [7:0]  a1_ex_reg, a1_ex_next;
    logic [26:0] a1_big_reg, a1_big_next, a1_sm_reg, a1_sm_next;

    logic [27:0] a2_s_reg, a2_s_next;
    logic [7:0]  a2_ex_reg;
    logic        a2_zs_reg;

    logic [8:0]  e9;
    logic [5:0]  lz;
    logic [7:0]  lim, sh;
    logic [26:0] a3_sn_reg, a3_sn_next;
    logic [7:0]  a3_ef_reg, a3_ef_next;
    logic        a3_ovf_reg, a3_ovf_next, a3_zero_reg, a3_zero_next, a3_zs_reg;

    logic [30:0] r;
    logic [31:0] s_reg, s_next;

    always_comb
    begin
        x_nan = (&x[30:23]) & (|x[22:0]);
        y_nan = (&y[30:23]) & (|y[22:0]);
        x_inf = (&x[30:23]) & ~(|x[22:0]);
        y_inf = (&y[30:23]) & ~(|y[22:0]);
        if (x[30:0] >= y[30:0])
        begin
            big = x;
            sml = y;
        end
        else
        begin
            big = y;
            sml = x;
        end
        exb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        exs   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d     = exb - exs;
        smf   = {|sml[30:23], sml[22:0], 3'b000};
        sm_sh = smf >> d;
        lost  = |(smf & ((27'h1 << d) - 27'h1));
        if (d >= 8'd27)
            a1_sm_next = {26'd0, |smf};
        else
            a1_sm_next = {sm_sh[26:1], sm_sh[0] | lost};
        a1_big_next       = {|big[30:23], big[22:0], 3'b000};
        a1_ex_next        = exb;
        a1_sub_next       = x[31] ^ y[31];
        a1_zs_next        = x[31] & y[31];
        a1_spec_next.nan  = x_nan | y_nan | (x_inf & y_inf & (x[31] ^ y[31]));
        a1_spec_next.inf  = x_inf | y_inf;
        a1_spec_next.zero = 1'b0;
        a1_spec_next.sign = big[31];
    end

    always_comb
    begin
        if (a1_sub_reg)
            a2_s_next = {1'b0, a1_big_reg} - {1'b0, a1_sm_reg};
        else
            a2_s_next = {1'b0, a1_big_reg} + {1'b0, a1_sm_reg};
    end

    always_comb
    begin
        e9  = {1'b0, a2_ex_reg} + 9'd1;
        lz  = wec_pkg::lzc48({a2_s_reg[26:0], 21'd0});
        lim = a2_ex_reg - 8'd1;
        sh  = ({2'b0, lz} < lim) ? {2'b0, lz} : lim;
        a3_zero_next = (a2_s_reg == 28'd0);
        if (a2_s_reg[27])
        begin
            a3_sn_next  = {a2_s_reg[27:2], a2_s_reg[1] | a2_s_reg[0]};
            a3_ef_next  = e9[7:0];
            a3_ovf_next = (e9 >= 9'd255);
        end
        else
        begin
            a3_sn_next  = a2_s_reg[26:0] << sh;
            a3_ef_next  = a3_sn_next[26] ? (a2_ex_reg - sh) : 8'd0;
            a3_ovf_next = 1'b0;
        end
    end

    always_comb
    begin
        r = wec_pkg::round_rne(a3_ef_reg, a3_sn_reg[26:3], a3_sn_reg[2], |a3_sn_reg[1:0]);
        if (a3_spec_reg.nan)
            s_next = wec_pkg::CANON_NAN;
        else if (a3_spec_reg.inf || a3_ovf_reg)
            s_next = {a3_spec_reg.sign, 8'hFF, 23'd0};
        else if (a3_zero_reg)
            s_next = {a3_zs_reg, 31'd0};
        else
            s_next = {a3_spec_reg.sign, r};
    end

    always_ff @(posedge clk)
    begin
        a1_spec_reg <= a1_spec_next;
        a1_sub_reg  <= a1_sub_next;
        a1_zs_reg   <= a1_zs_next;
        a1_ex_reg   <= a1_ex_next;
        a1_big_reg  <= a1_big_next;
        a1_sm_reg   <= a1_sm_next;
        a2_spec_reg <= a1_spec_reg;
        a2_s_reg    <= a2_s_next;
        a2_ex_reg   <= a1_ex_reg;
        a2_zs_reg   <= a1_zs_reg;
        a3_spec_reg <= a2_spec_reg;
        a3_sn_reg   <= a3_sn_next;
        a3_ef_reg   <= a3_ef_next;
        a3_ovf_reg  <= a3_ovf_next;
        a3_zero_reg <= a3_zero_next;
        a3_zs_reg   <= a2_zs_reg;
        s_reg       <= s_next;
    end

    assign s = s_reg;

endmodule

// ----- rtl/weighted_elementwise_combine.sv -----
// Top level: config registers, max compare, two multipliers feeding an adder, result mux.
// Depends on wec_pkg, wec_fmul, wec_fadd.
//
//  channel  | ports                                                  | flow
//  ---------+--------------------------------------------------------+-----------------
//  config   | cfg_we, cfg_idx, cfg_data                              | write, no wait
//  item in  | start, busy, acc_value, operand_value, acc_weight,     | start & !busy
//           | operand_weight                                         |
//  item out | done, result_value                                     | one-cycle strobe
//
// One item per cycle; in every mode the delay from accept to done matches
// the 3 multiplier stages, 4 adder stages and the output register.
// busy is always low. Reset clears the valid line and sets op_mode 1, value_format 0.
// Results leave on done without back pressure.
module weighted_elementwise_combine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [1:0]  cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] acc_value,
    input  logic [31:0] operand_value,
    input  logic [31:0] acc_weight,
    input  logic [31:0] operand_weight,
    output logic        done,
    output logic [31:0] result_value
);

    wec_pkg::mode_t mode_reg, mode_next;
    logic           bf_reg, bf_next;

    logic [wec_pkg::LATENCY-1:0] valid_reg, valid_next;
    wec_pkg::tag_t tag_reg  [wec_pkg::TAG_DEPTH];
    wec_pkg::tag_t tag_next [wec_pkg::TAG_DEPTH];

    logic [31:0] aw, ow, m0b, prod0, prod1, sum;
    logic        a_nan, o_nan, both_zero, lt, accept;
    logic [31:0] res, result_reg, result_next;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_comb
    begin
        mode_next = mode_reg;
        bf_next   = bf_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                wec_pkg::CFG_OP_MODE:      mode_next = wec_pkg::mode_t'(cfg_data);
                wec_pkg::CFG_VALUE_FORMAT: bf_next   = cfg_data[0];
                default:                   mode_next = mode_reg;
            endcase
        end
    end

    always_comb
    begin
        aw        = bf_reg ? {acc_value[15:0], 16'd0} : acc_value;
        ow        = bf_reg ? {operand_value[15:0], 16'd0} : operand_value;
        m0b       = (mode_reg == wec_pkg::MODE_PROD) ? ow : acc_weight;
        a_nan     = (&aw[30:23]) & (|aw[22:0]);
        o_nan     = (&ow[30:23]) & (|ow[22:0]);
        both_zero = ~(|aw[30:0]) & ~(|ow[30:0]);
        if (a_nan || o_nan || both_zero)
            lt = 1'b0;
        else if (aw[31] != ow[31])
            lt = ow[31];
        else if (!ow[31])
            lt = ow[30:0] < aw[30:0];
        else
            lt = ow[30:0] > aw[30:0];
    end

    wec_fmul u_mul0 (.clk(clk), .a(aw), .b(m0b), .p(prod0));
    wec_fmul u_mul1 (.clk(clk), .a(ow), .b(operand_weight), .p(prod1));
    wec_fadd u_add  (.clk(clk), .x(prod0), .y(prod1), .s(sum));

    always_comb
    begin
        valid_next       = {valid_reg[wec_pkg::LATENCY-2:0], accept};
        tag_next[0].mode = mode_reg;
        tag_next[0].bf   = bf_reg;
        tag_next[0].alt  = lt ? aw : ow;
        for (int k = 1; k < wec_pkg::TAG_DEPTH; k++)
            tag_next[k] = tag_reg[k-1];
        if (tag_reg[2].mode == wec_pkg::MODE_PROD)
            tag_next[3].alt = prod0;
    end

    always_comb
    begin
        case (tag_reg[wec_pkg::TAG_DEPTH-1].mode)
            wec_pkg::MODE_PROD: res = tag_reg[wec_pkg::TAG_DEPTH-1].alt;
            wec_pkg::MODE_SUM:  res = sum;
            wec_pkg::MODE_MAX:  res = tag_reg[wec_pkg::TAG_DEPTH-1].alt;
            default:            res = 32'd0;
        endcase
        if (tag_reg[wec_pkg::TAG_DEPTH-1].bf)
            result_next = {16'd0, res[31:16]};
        else
            result_next = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= wec_pkg::MODE_SUM;
            bf_reg    <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            bf_reg    <= bf_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < wec_pkg::TAG_DEPTH; k++)
            tag_reg[k] <= tag_next[k];
        result_reg <= result_next;
    end

    assign done         = valid_reg[wec_pkg::LATENCY-1];
    assign result_value = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##8 done)
        else $error("item did not complete after fixed latency");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[wec_pkg::TAG_DEPTH-1] &&
        tag_reg[wec_pkg::TAG_DEPTH-1].mode == wec_pkg::MODE_NONE |=> result_value == 32'd0)
        else $error("unused mode gave nonzero result");

    a_bf_upper: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[wec_pkg::TAG_DEPTH-1] && tag_reg[wec_pkg::TAG_DEPTH-1].bf
        |=> result_value[31:16] == 16'd0)
        else $error("bf16 result has upper bits set");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(valid_reg[wec_pkg::LATENCY-2]))
        else $error("done without an item in flight");

endmodule
